// ===== rtl/wrhd_pkg.sv =====
// wrhd_pkg: shared types and constants of the window range hit detector.
// No dependencies; used by every rtl file but wrhd_ram through scoped names.
package wrhd_pkg;

    localparam int RANGE_BITS = 10;   // width of thresholds and range outputs
    localparam int CFG_IDX_W  = 1;

    localparam logic [RANGE_BITS-1:0] RISE_THR_RESET = 10'd20;
    localparam logic [RANGE_BITS-1:0] FALL_THR_RESET = 10'd10;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RISE_THR = 1'b0,
        REG_FALL_THR = 1'b1
    } cfg_reg_t;

    // spike detector states
    typedef enum logic [2:0] {
        DET_IDLE    = 3'b001,
        DET_RISING  = 3'b010,
        DET_FALLING = 3'b100
    } det_state_t;

    // sequencer states
    typedef enum logic [3:0] {
        SEQ_IDLE = 4'b0001,
        SEQ_SCAN = 4'b0010,
        SEQ_LAST = 4'b0100,
        SEQ_EVAL = 4'b1000
    } seq_state_t;

    // controller -> datapath
    typedef struct packed {
        logic start;   // request accepted: store sample, open a scan
        logic rd;      // read one window entry
        logic eval;    // run detector, load result register
    } wrhd_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_last;   // current scan address is the last entry
    } wrhd_stat_t;

endpackage

// ===== rtl/wrhd_ram.sv =====
// wrhd_ram: generic single write port, single read port RAM, registered read.
// No dependencies.
module wrhd_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 50,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/wrhd_datapath.sv =====
// wrhd_datapath: window RAM, fill tracking, min/max scan, spike detector,
// threshold registers and result register. Depends on wrhd_pkg, wrhd_ram.
module wrhd_datapath #(
    parameter int WINDOW_SIZE = 50,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [wrhd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wrhd_pkg::RANGE_BITS-1:0] cfg_data,
    input  logic [SAMPLE_BITS-1:0]         sample,
    input  wrhd_pkg::wrhd_cmd_t            cmd,
    output wrhd_pkg::wrhd_stat_t           stat,
    output logic                           hit,
    output logic [wrhd_pkg::RANGE_BITS-1:0] hit_level,
    output logic                           indicator,
    output logic [wrhd_pkg::RANGE_BITS-1:0] window_range
);

    localparam int IDX_W  = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int FILL_W = $clog2(WINDOW_SIZE + 1);
    localparam int CMP_W  = (SAMPLE_BITS > wrhd_pkg::RANGE_BITS) ?
                            SAMPLE_BITS : wrhd_pkg::RANGE_BITS;
    localparam int RB     = wrhd_pkg::RANGE_BITS;

    logic [RB-1:0]          rise_thr_reg, rise_thr_next;
    logic [RB-1:0]          fall_thr_reg, fall_thr_next;
    logic [IDX_W-1:0]       wr_idx_reg, wr_idx_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [IDX_W-1:0]       scan_addr_reg, scan_addr_next;
    logic                   rd_pend_reg;
    logic                   rd_live_reg;
    logic [SAMPLE_BITS-1:0] min_reg, min_next;
    logic [SAMPLE_BITS-1:0] max_reg, max_next;
    logic [CMP_W-1:0]       peak_reg, peak_next;
    wrhd_pkg::det_state_t   det_reg, det_next;
    logic                   ind_reg, ind_next;
    logic                   hit_reg;
    logic [RB-1:0]          hit_level_reg;
    logic                   out_ind_reg;
    logic [RB-1:0]          range_reg;

    logic [SAMPLE_BITS-1:0] ram_rd_data;
    logic [SAMPLE_BITS-1:0] entry_val;
    logic [SAMPLE_BITS-1:0] span;
    logic [CMP_W-1:0]       span_c;
    logic                   hit_now;
    logic [CMP_W-1:0]       level_now;

    wrhd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_SIZE),
        .ADDR_W(IDX_W)
    ) u_window (
        .clk    (clk),
        .wr_en  (cmd.start),
        .wr_addr(wr_idx_reg),
        .wr_data(sample),
        .rd_en  (cmd.rd),
        .rd_addr(scan_addr_reg),
        .rd_data(ram_rd_data)
    );

    // configuration
    always_comb
    begin
        rise_thr_next = rise_thr_reg;
        fall_thr_next = fall_thr_reg;
        if (cfg_write)
        begin
            unique case (wrhd_pkg::cfg_reg_t'(cfg_index))
                wrhd_pkg::REG_RISE_THR: rise_thr_next = cfg_data;
                wrhd_pkg::REG_FALL_THR: fall_thr_next = cfg_data;
                default: ;
            endcase
        end
    end

    // ring pointer and fill count; entries at or above fill read as zero
    always_comb
    begin
        wr_idx_next = wr_idx_reg;
        fill_next   = fill_reg;
        if (cmd.start)
        begin
            if (wr_idx_reg == IDX_W'(WINDOW_SIZE - 1))
            begin
                wr_idx_next = '0;
            end
            else
            begin
                wr_idx_next = wr_idx_reg + 1'b1;
            end
            if (fill_reg != FILL_W'(WINDOW_SIZE))
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    // scan
    assign stat.scan_last = (scan_addr_reg == IDX_W'(WINDOW_SIZE - 1));
    assign entry_val      = rd_live_reg ? ram_rd_data : '0;

    always_comb
    begin
        scan_addr_next = scan_addr_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        if (cmd.start)
        begin
            scan_addr_next = '0;
            min_next       = '1;
            max_next       = '0;
        end
        else
        begin
            if (cmd.rd)
            begin
                scan_addr_next = scan_addr_reg + 1'b1;
            end
            if (rd_pend_reg)
            begin
                if (entry_val < min_reg)
                begin
                    min_next = entry_val;
                end
                if (entry_val > max_reg)
                begin
                    max_next = entry_val;
                end
            end
        end
    end

    // detector
    assign span   = max_reg - min_reg;
    assign span_c = CMP_W'(span);

    always_comb
    begin
        det_next  = det_reg;
        peak_next = peak_reg;
        ind_next  = ind_reg;
        hit_now   = 1'b0;
        level_now = '0;
        unique case (det_reg)
            wrhd_pkg::DET_IDLE:
            begin
                if (span_c > CMP_W'(rise_thr_reg))
                begin
                    det_next  = wrhd_pkg::DET_RISING;
                    peak_next = span_c;
                end
            end
            wrhd_pkg::DET_RISING:
            begin
                if (span_c < peak_reg)
                begin
                    det_next  = wrhd_pkg::DET_FALLING;
                    ind_next  = 1'b1;
                    hit_now   = 1'b1;
                    level_now = peak_reg;
                end
                else
                begin
                    peak_next = span_c;
                end
            end
            default:
            begin
                det_next = wrhd_pkg::DET_FALLING;
                if (span_c < CMP_W'(fall_thr_reg))
                begin
                    det_next = wrhd_pkg::DET_IDLE;
                    ind_next = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rise_thr_reg  <= wrhd_pkg::RISE_THR_RESET;
            fall_thr_reg  <= wrhd_pkg::FALL_THR_RESET;
            wr_idx_reg    <= '0;
            fill_reg      <= '0;
            scan_addr_reg <= '0;
            rd_pend_reg   <= 1'b0;
            rd_live_reg   <= 1'b0;
            peak_reg      <= '0;
            det_reg       <= wrhd_pkg::DET_FALLING;
            ind_reg       <= 1'b0;
        end
        else
        begin
            rise_thr_reg  <= rise_thr_next;
            fall_thr_reg  <= fall_thr_next;
            wr_idx_reg    <= wr_idx_next;
            fill_reg      <= fill_next;
            scan_addr_reg <= scan_addr_next;
            rd_pend_reg   <= cmd.rd;
            rd_live_reg   <= (FILL_W'(scan_addr_reg) < fill_reg);
            if (cmd.eval)
            begin
                peak_reg <= peak_next;
                det_reg  <= det_next;
                ind_reg  <= ind_next;
            end
        end
    end

    // scan accumulators and result payload
    always_ff @(posedge clk)
    begin
        min_reg <= min_next;
        max_reg <= max_next;
        if (cmd.eval)
        begin
            hit_reg       <= hit_now;
            hit_level_reg <= level_now[RB-1:0];
            out_ind_reg   <= ind_next;
            range_reg     <= span_c[RB-1:0];
        end
    end

    assign hit          = hit_reg;
    assign hit_level    = hit_level_reg;
    assign indicator    = out_ind_reg;
    assign window_range = range_reg;

endmodule

// ===== rtl/wrhd_ctrl.sv =====
// wrhd_ctrl: sequencer for one sample (store, scan, evaluate) and the
// result handshake. Depends on wrhd_pkg.
module wrhd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  wrhd_pkg::wrhd_stat_t stat,
    output wrhd_pkg::wrhd_cmd_t  cmd
);

    wrhd_pkg::seq_state_t state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;

    assign in_ready = (state_reg == wrhd_pkg::SEQ_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            wrhd_pkg::SEQ_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = wrhd_pkg::SEQ_SCAN;
                end
            end
            wrhd_pkg::SEQ_SCAN:
            begin
                cmd.rd = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = wrhd_pkg::SEQ_LAST;
                end
            end
            wrhd_pkg::SEQ_LAST:
            begin
                state_next = wrhd_pkg::SEQ_EVAL;
            end
            wrhd_pkg::SEQ_EVAL:
            begin
                // wait for the result slot to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.eval   = 1'b1;
                    state_next = wrhd_pkg::SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = wrhd_pkg::SEQ_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.eval)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wrhd_pkg::SEQ_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/window_range_hit_detector.sv =====
// window_range_hit_detector: top level. Depends on wrhd_pkg, wrhd_ctrl, wrhd_datapath.
// Throughput is set by the scan of the window RAM through its single read port, one
// entry a cycle; no new sample is taken until the previous one has been evaluated.
// Reset (rst_n, async, active low): window reads as all zeros through a fill count,
// detector in falling, indicator off, thresholds 20 and 10; no clearing pass.
module window_range_hit_detector #(
    parameter int WINDOW_SIZE = 50,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration writes, taken whenever cfg_write is high
    input  logic                            cfg_write,
    input  logic [wrhd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wrhd_pkg::RANGE_BITS-1:0] cfg_data,
    // sample requests
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [SAMPLE_BITS-1:0]          sample,
    // result requests
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            hit,
    output logic [wrhd_pkg::RANGE_BITS-1:0] hit_level,
    output logic                            indicator,
    output logic [wrhd_pkg::RANGE_BITS-1:0] window_range
);

    // The controller walks each sample through store, scan of every window
    // entry, a drain state for the registered RAM read, and evaluation.
    // The result sits in its own register, so a new sample is taken while
    // the previous result still waits for out_ready.
    wrhd_pkg::wrhd_cmd_t  cmd;
    wrhd_pkg::wrhd_stat_t stat;

    wrhd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: ring RAM with fill count (unwritten entries count as zero),
    // min/max accumulators, the idle/rising/falling detector with its peak,
    // the threshold registers and the result payload register.
    wrhd_datapath #(
        .WINDOW_SIZE(WINDOW_SIZE),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .sample      (sample),
        .cmd         (cmd),
        .stat        (stat),
        .hit         (hit),
        .hit_level   (hit_level),
        .indicator   (indicator),
        .window_range(window_range)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking bench for window_range_hit_detector (piezo spike / hit detection).
// Depends directly on rtl/wrhd_pkg.sv and rtl/window_range_hit_detector.sv only.
module tb;

    localparam int WINDOW_SIZE = 50;
    localparam int SAMPLE_BITS = 10;
    localparam int RANGE_BITS  = wrhd_pkg::RANGE_BITS;
    localparam int DIR_ROWS    = 20;
    localparam int RAND_ITEMS  = 400;
    localparam int LONG_HOLD   = 400;   // receiver hold-off, long enough to back up the input
    localparam int TAIL_CYCLES = WINDOW_SIZE + 3;
    localparam int MAX_SHOWN   = 10;

    // one result request, field for field as it leaves the block
    typedef struct packed {
        logic                  hit;
        logic [RANGE_BITS-1:0] level;
        logic                  ind;
        logic [RANGE_BITS-1:0] win_range;
    } hit_report_t;

    // directed row: a sample, plus a hand-written result where it is obvious
    typedef struct packed {
        logic                   pin;
        logic [SAMPLE_BITS-1:0] smp;
        hit_report_t            want;
    } dir_row_t;

    localparam hit_report_t NO_PIN = '0;

    // Window starts as all zeros at default thresholds 20 / 10.
    // First sample keeps range 0: falling drops to idle, indicator stays off.
    // 1023 opens a full-scale range: idle goes rising with peak 1023.
    // Next samples keep the range equal, so rising holds and no hit comes out.
    // The rest walk each sample bit and are left to the predictor.
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{1'b1, 10'd0,    '{1'b0, 10'd0, 1'b0, 10'd0}},
        '{1'b1, 10'd1023, '{1'b0, 10'd0, 1'b0, 10'd1023}},
        '{1'b1, 10'd0,    '{1'b0, 10'd0, 1'b0, 10'd1023}},
        '{1'b1, 10'd512,  '{1'b0, 10'd0, 1'b0, 10'd1023}},
        '{1'b0, 10'd1,    NO_PIN},
        '{1'b0, 10'd2,    NO_PIN},
        '{1'b0, 10'd4,    NO_PIN},
        '{1'b0, 10'd8,    NO_PIN},
        '{1'b0, 10'd16,   NO_PIN},
        '{1'b0, 10'd32,   NO_PIN},
        '{1'b0, 10'd64,   NO_PIN},
        '{1'b0, 10'd128,  NO_PIN},
        '{1'b0, 10'd256,  NO_PIN},
        '{1'b0, 10'd511,  NO_PIN},
        '{1'b0, 10'd1022, NO_PIN},
        '{1'b0, 10'd341,  NO_PIN},
        '{1'b0, 10'd682,  NO_PIN},
        '{1'b0, 10'd0,    NO_PIN},
        '{1'b0, 10'd1023, NO_PIN},
        '{1'b0, 10'd512,  NO_PIN}
    };

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             cfg_write;
    logic [wrhd_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [RANGE_BITS-1:0]            cfg_data;
    logic                             in_valid;
    logic                             in_ready;
    logic [SAMPLE_BITS-1:0]           sample;
    logic                             out_valid;
    logic                             out_ready;
    logic                             hit;
    logic [RANGE_BITS-1:0]            hit_level;
    logic                             indicator;
    logic [RANGE_BITS-1:0]            window_range;

    window_range_hit_detector #(
        .WINDOW_SIZE(WINDOW_SIZE),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .sample      (sample),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hit         (hit),
        .hit_level   (hit_level),
        .indicator   (indicator),
        .window_range(window_range)
    );

    always #6 clk = ~clk;

    // ---------------------------------------------------------------------
    // Detector predictor: private copy of window, detector and thresholds
    // ---------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] win_mem [WINDOW_SIZE];
    int                     win_ptr;
    logic [RANGE_BITS-1:0]  peak_seen;
    wrhd_pkg::det_state_t   det_now;
    logic                   ind_on;
    logic [RANGE_BITS-1:0]  thr_rise;
    logic [RANGE_BITS-1:0]  thr_fall;

    // expected results in request order; pinned ones override the predictor
    hit_report_t pending_results [$];
    hit_report_t pinned_result [int];

    int n_sent;        // sample requests accepted, counted by the sender
    int n_out;         // result requests accepted (NBA, safe to read at the edge)
    int n_accepted;    // sample requests seen by the scoreboard
    int fail_count;
    int burst_left;
    int baseline;
    int noise_amp;

    function automatic hit_report_t advance_detector(input logic [SAMPLE_BITS-1:0] smp);
        hit_report_t           r;
        logic [SAMPLE_BITS-1:0] lo;
        logic [SAMPLE_BITS-1:0] hi;
        logic [RANGE_BITS-1:0]  span;
        int                     k;
        r = '0;
        win_mem[win_ptr] = smp;
        win_ptr = (win_ptr == WINDOW_SIZE - 1) ? 0 : win_ptr + 1;
        lo = win_mem[0];
        hi = win_mem[0];
        for (k = 1; k < WINDOW_SIZE; k++)
        begin
            if (win_mem[k] < lo)
                lo = win_mem[k];
            if (win_mem[k] > hi)
                hi = win_mem[k];
        end
        span = RANGE_BITS'(hi - lo);
        case (det_now)
            wrhd_pkg::DET_IDLE:
                if (span > thr_rise)
                begin
                    det_now   = wrhd_pkg::DET_RISING;
                    peak_seen = span;
                end
            wrhd_pkg::DET_RISING:
                // equal range is not a drop: peak just follows
                if (span < peak_seen)
                begin
                    det_now = wrhd_pkg::DET_FALLING;
                    ind_on  = 1'b1;
                    r.hit   = 1'b1;
                    r.level = peak_seen;
                end
                else
                    peak_seen = span;
            default:
            begin
                det_now = wrhd_pkg::DET_FALLING;
                if (span < thr_fall)
                begin
                    det_now = wrhd_pkg::DET_IDLE;
                    ind_on  = 1'b0;
                end
            end
        endcase
        r.ind       = ind_on;
        r.win_range = span;
        return r;
    endfunction

    function automatic void note_failure(input string what);
        if (fail_count < MAX_SHOWN)
            $display("[%0t] MISMATCH: %s", $realtime, what);
        fail_count++;
    endfunction

    // ---------------------------------------------------------------------
    // Scoreboard: predict on sample accept, check on result accept.
    // Results go out before the new prediction is queued in the same edge.
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin : scoreboard
        hit_report_t want;
        hit_report_t fresh;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                n_out <= n_out + 1;
                if (pending_results.size() == 0)
                    note_failure($sformatf(
                        "result %0d with no request pending: hit=%0d lvl=%0d ind=%0d rng=%0d",
                        n_out, hit, hit_level, indicator, window_range));
                else
                begin
                    want = pending_results.pop_front();
                    if (hit !== want.hit)
                        note_failure($sformatf("result %0d hit: exp %0d got %0d",
                                               n_out, want.hit, hit));
                    if (hit_level !== want.level)
                        note_failure($sformatf("result %0d hit_level: exp %0d got %0d",
                                               n_out, want.level, hit_level));
                    if (indicator !== want.ind)
                        note_failure($sformatf("result %0d indicator: exp %0d got %0d",
                                               n_out, want.ind, indicator));
                    if (window_range !== want.win_range)
                        note_failure($sformatf("result %0d window_range: exp %0d got %0d",
                                               n_out, want.win_range, window_range));
                end
            end
            if (in_valid && in_ready)
            begin
                fresh = advance_detector(sample);
                if (pinned_result.exists(n_accepted))
                    fresh = pinned_result[n_accepted];
                pending_results.push_back(fresh);
                n_accepted++;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Sender helpers. All are entered and left right after a rising edge.
    // ---------------------------------------------------------------------

    // Offer one sample in bursts; a gap drops valid only when it really idles,
    // so valid is never lowered and raised in the same step.
    task automatic send_item(input logic [SAMPLE_BITS-1:0] smp);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 70);
            burst_left = $urandom_range(1, 10);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        sample   <= smp;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        n_sent++;
    endtask

    // stop offering and wait until every request has its result back
    task automatic wait_idle();
        in_valid  <= 1'b0;
        burst_left = 0;
        while (n_out != n_sent)
            @(posedge clk);
    endtask

    task automatic set_thresholds(input logic [RANGE_BITS-1:0] rise,
                                  input logic [RANGE_BITS-1:0] fall);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_index <= wrhd_pkg::REG_RISE_THR;
        cfg_data  <= rise;
        @(posedge clk);
        cfg_index <= wrhd_pkg::REG_FALL_THR;
        cfg_data  <= fall;
        @(posedge clk);
        cfg_write <= 1'b0;
        thr_rise = rise;
        thr_fall = fall;
    endtask

    // resting signal: baseline plus a little noise
    task automatic play_quiet(input int count);
        int k;
        for (k = 0; k < count; k++)
            send_item(SAMPLE_BITS'(baseline + $urandom_range(0, noise_amp)));
    endtask

    // a spike climbing away from baseline in a few steps, up or down
    task automatic play_spike();
        int  steps;
        int  dev;
        int  v;
        int  k;
        bit  down;
        steps = $urandom_range(1, 5);
        dev   = $urandom_range(15, 511);
        down  = $urandom_range(0, 1);
        for (k = 1; k <= steps; k++)
        begin
            v = down ? baseline - dev * k / steps : baseline + dev * k / steps;
            if (v < 0)
                v = 0;
            if (v > 1023)
                v = 1023;
            send_item(v[SAMPLE_BITS-1:0]);
        end
    endtask

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    initial
    begin : stimulus
        int i;
        int k;
        int pattern_no;
        int cfg_no;
        int pick;

        // predictor at its reset state
        for (i = 0; i < WINDOW_SIZE; i++)
            win_mem[i] = '0;
        win_ptr    = 0;
        peak_seen  = '0;
        det_now    = wrhd_pkg::DET_FALLING;
        ind_on     = 1'b0;
        thr_rise   = wrhd_pkg::RISE_THR_RESET;
        thr_fall   = wrhd_pkg::FALL_THR_RESET;
        n_sent     = 0;
        n_out      = 0;
        n_accepted = 0;
        fail_count = 0;
        burst_left = 0;

        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= wrhd_pkg::REG_RISE_THR;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        sample    <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at reset thresholds
        for (i = 0; i < DIR_ROWS; i++)
        begin
            if (DIR_TABLE[i].pin)
                pinned_result[n_sent] = DIR_TABLE[i].want;
            send_item(DIR_TABLE[i].smp);
        end

        // Random part: mostly rest / spike / rest shapes so the detector walks
        // idle -> rising -> hit -> falling -> idle, with some raw noise and
        // broken shapes. Thresholds change every other shape, extremes first.
        cfg_no     = 0;
        pattern_no = 0;
        while (n_sent < DIR_ROWS + RAND_ITEMS)
        begin
            if (pattern_no % 2 == 0)
            begin
                case (cfg_no)
                    0: set_thresholds(10'd1023, 10'd0);     // never rises, never rearms
                    1: set_thresholds(10'd0, 10'd1023);     // hair trigger, instant rearm
                    2: set_thresholds(10'd0, 10'd0);
                    3: set_thresholds(10'd1023, 10'd1023);
                    default:
                        if ($urandom_range(0, 5) == 0)
                            set_thresholds(10'($urandom_range(0, 1023)),
                                           10'($urandom_range(0, 1023)));
                        else
                            set_thresholds(10'($urandom_range(8, 60)),
                                           10'($urandom_range(2, 30)));
                endcase
                cfg_no++;
            end
            baseline  = $urandom_range(420, 600);
            noise_amp = $urandom_range(0, 6);
            pick      = $urandom_range(0, 9);
            if (pick <= 4)
            begin
                // clean hit: spike, then rest until it leaves the window
                play_spike();
                play_quiet($urandom_range(WINDOW_SIZE, WINDOW_SIZE + 12));
            end
            else if (pick <= 6)
                play_quiet($urandom_range(20, 60));
            else if (pick == 7)
            begin
                for (k = $urandom_range(3, 12); k > 0; k--)
                    send_item(SAMPLE_BITS'($urandom_range(0, 1023)));
            end
            else if (pick == 8)
            begin
                // second spike lands while the first is still in the window
                play_spike();
                play_quiet($urandom_range(5, 40));
                play_spike();
                play_quiet($urandom_range(WINDOW_SIZE, WINDOW_SIZE + 12));
            end
            else
            begin
                for (k = $urandom_range(4, 10); k > 0; k--)
                    send_item((k % 2) ? '1 : '0);
            end
            pattern_no++;
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            note_failure($sformatf("%0d results never arrived", pending_results.size()));
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Receiver: stretches of full rate, light and heavy stalling, plus one
    // long hold-off while the sender is still offering.
    // ---------------------------------------------------------------------
    initial
    begin : result_sink
        int  mode;
        int  span_len;
        bit  held;
        held = 1'b0;
        out_ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            if (!held && n_out >= 120 && in_valid)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            mode     = $urandom_range(0, 2);
            span_len = $urandom_range(10, 150);
            repeat (span_len)
            begin
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 3) != 0);
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // watchdog, several times the slowest legal run
    initial
    begin : watchdog
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/wrhd_pkg.sv
rtl/wrhd_ram.sv
rtl/wrhd_datapath.sv
rtl/wrhd_ctrl.sv
rtl/window_range_hit_detector.sv
tb/tb.sv
